[rtl/core/rtmpch_pkg.sv]
// Package for the RTMP chunk header parser.
// Holds the chunk type codes, field widths, the stored header entry and the
// table port structs. No dependencies.
package rtmpch_pkg;

  // Field widths
  localparam int SID_W      = 6;
  localparam int BIDX_W     = 4;
  localparam int BODY_BYTES = 11;

  // Timestamp or delta field of all ones announces an extended timestamp
  localparam logic [23:0] ALL24 = 24'hFF_FFFF;

  // Number of extended timestamp bytes
  localparam logic [BIDX_W-1:0] EXT_BYTES = 4'd4;

  // Message header lengths per chunk type
  localparam logic [BIDX_W-1:0] BODY_LEN_FULL    = 4'd11;
  localparam logic [BIDX_W-1:0] BODY_LEN_NO_MSID = 4'd7;
  localparam logic [BIDX_W-1:0] BODY_LEN_DELTA   = 4'd3;
  localparam logic [BIDX_W-1:0] BODY_LEN_NONE    = 4'd0;

  // Chunk type from the basic header
  typedef enum logic [1:0] {
    CT_FULL    = 2'd0,
    CT_NO_MSID = 2'd1,
    CT_DELTA   = 2'd2,
    CT_NONE    = 2'd3
  } chunk_type_e;

  // One decoded header as kept per stream
  typedef struct packed {
    logic [31:0] ts;
    logic [23:0] delta;
    logic [23:0] len;
    logic [7:0]  mtype;
    logic [31:0] msid;
  } hdr_entry_t;

  // Write request into the header table
  typedef struct packed {
    logic             en;
    logic [SID_W-1:0] sid;
    hdr_entry_t       data;
  } hdr_wr_t;

  // Lookup result for a stream id
  typedef struct packed {
    logic hit;  // a previous header exists
    logic ext;  // previous delta was all ones
  } store_look_t;

  // Message header length for a chunk type
  function automatic logic [BIDX_W-1:0] body_len(chunk_type_e ct);
    logic [BIDX_W-1:0] n;
    unique case (ct)
      CT_FULL:    n = BODY_LEN_FULL;
      CT_NO_MSID: n = BODY_LEN_NO_MSID;
      CT_DELTA:   n = BODY_LEN_DELTA;
      default:    n = BODY_LEN_NONE;
    endcase
    return n;
  endfunction

endpackage

[rtl/core/rtmpch_store.sv]
// Per-stream table of previous headers for the RTMP chunk header parser.
// Memory with registered read, valid bits and same-edge write forwarding.
// Depends on rtmpch_pkg.
module rtmpch_store #(
  parameter int STREAM_IDS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rtmpch_pkg::SID_W-1:0]   lk_sid_i,
  input  logic                           rd_en_i,
  input  rtmpch_pkg::hdr_wr_t            wr_i,
  output rtmpch_pkg::store_look_t        look_o,
  output rtmpch_pkg::hdr_entry_t         rd_data_o
);
  import rtmpch_pkg::*;

  localparam int AW = (STREAM_IDS > 1) ? $clog2(STREAM_IDS) : 1;
  localparam int CW = SID_W + 1;

  logic [STREAM_IDS-1:0] valid_q;
  logic [STREAM_IDS-1:0] ext_q;
  hdr_entry_t            mem [STREAM_IDS];
  hdr_entry_t            rd_q;
  hdr_entry_t            byp_data_q;
  logic                  byp_q;

  logic [AW-1:0] lk_addr;
  logic [AW-1:0] wr_addr;
  logic          lk_in;
  logic          wr_go;
  logic          fwd;

  // Address decode and range checks
  assign lk_addr = lk_sid_i[AW-1:0];
  assign wr_addr = wr_i.sid[AW-1:0];
  assign lk_in   = {1'b0, lk_sid_i} < CW'(STREAM_IDS);
  assign wr_go   = wr_i.en && ({1'b0, wr_i.sid} < CW'(STREAM_IDS));
  assign fwd     = wr_go && (wr_i.sid == lk_sid_i);

  // Lookup sees a write landing on the same edge
  assign look_o.hit = lk_in && (valid_q[lk_addr] || fwd);
  assign look_o.ext = fwd ? (wr_i.data.delta == ALL24) : ext_q[lk_addr];

  // Read data, replaced by the write that coincided with the read
  assign rd_data_o = byp_q ? byp_data_q : rd_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_go) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  // Table storage and registered read
  always_ff @(posedge clk_i) begin
    if (wr_go) begin
      mem[wr_addr]   <= wr_i.data;
      ext_q[wr_addr] <= (wr_i.data.delta == ALL24);
    end
    if (rd_en_i) begin
      rd_q       <= mem[lk_addr];
      byp_q      <= fwd;
      byp_data_q <= wr_i.data;
    end
  end

endmodule

[rtl/core/rtmp_chunk_header_parser.sv]
// RTMP chunk header parser, top level.
// Byte-wise parser, result stage and per-stream header table.
// Depends on rtmpch_pkg and rtmpch_store.
//
// Usage:
//   Input channel: one header byte per item (header_byte_i) with
//   start_of_header_i, which forces the byte to be taken as a basic header
//   and drops any partial header. Output channel: one decoded header per
//   completed chunk header, or an error item (status_o = 1) for type 2 or 3
//   on a stream with no stored header.
//   Throughput: one byte per cycle while in_stall_o is low, bounded by the
//   parser state register, which advances once per byte, and the single
//   write port of the table. Result path: the edge that accepts the last
//   byte of a header loads the result stage; the item moves on into the
//   output register once that register can take it.
//   Reset: all streams have no stored header and the parser awaits a
//   basic header byte; no clearing pass is needed.
//   Stall: out_stall_i holds the output register; a pending result then
//   holds the result stage and in_stall_o rises until the output frees up.
module rtmp_chunk_header_parser #(
  parameter int STREAM_IDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  header_byte_i,
  input  logic        start_of_header_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  chunk_stream_id_o,
  output logic [1:0]  chunk_type_o,
  output logic [31:0] absolute_timestamp_o,
  output logic [23:0] timestamp_delta_o,
  output logic [23:0] message_length_o,
  output logic [7:0]  message_type_o,
  output logic [31:0] message_stream_id_o,
  output logic        status_o
);
  import rtmpch_pkg::*;

  // Snapshot of a finished header handed to the result stage
  typedef struct packed {
    chunk_type_e      ctype;
    logic [SID_W-1:0] sid;
    logic             hp;
    logic             ext;
    logic             err;
    logic [23:0]      f0;
    logic [23:0]      len;
    logic [7:0]       mtype;
    logic [31:0]      msid;
    logic [31:0]      acc;
  } emit_t;

  // Registered result item
  typedef struct packed {
    logic [SID_W-1:0] sid;
    logic [1:0]       ctype;
    hdr_entry_t       hdr;
    logic             status;
  } result_t;

  // Parser state
  logic [BIDX_W-1:0] bidx_q, bidx_d;
  chunk_type_e       ctype_q, ctype_d;
  logic [SID_W-1:0]  sid_q, sid_d;
  logic              hp_q, hp_d;
  logic [31:0]       acc_q, acc_d;
  logic [7:0]        coll_q [BODY_BYTES];
  logic [7:0]        coll_d [BODY_BYTES];

  // Pipeline registers
  logic              s1_valid_q;
  emit_t             s1_q, s1_d;
  logic              out_valid_q;
  result_t           out_q;

  // Handshake and control
  logic              in_acc;
  logic              is_basic;
  logic              s1_adv;
  logic              emit;
  logic              emit_ext;
  logic              emit_err;
  logic [BIDX_W-1:0] n_len;

  // Table interface
  store_look_t       look;
  hdr_entry_t        prev;
  hdr_entry_t        pm;
  hdr_wr_t           wr;
  hdr_entry_t        res;
  logic [31:0]       ts_sum;

  // Handshakes: the result stage moves when the output register can take it
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_basic   = (bidx_q == '0) || start_of_header_i;
  assign n_len      = body_len(ctype_q);

  rtmpch_store #(
    .STREAM_IDS (STREAM_IDS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .lk_sid_i  (header_byte_i[SID_W-1:0]),
    .rd_en_i   (in_acc && is_basic),
    .wr_i      (wr),
    .look_o    (look),
    .rd_data_o (prev)
  );

  // Byte parser
  always_comb begin
    bidx_d   = bidx_q;
    ctype_d  = ctype_q;
    sid_d    = sid_q;
    hp_d     = hp_q;
    acc_d    = acc_q;
    coll_d   = coll_q;
    emit     = 1'b0;
    emit_ext = 1'b0;
    emit_err = 1'b0;
    if (in_acc) begin
      if (is_basic) begin
        ctype_d = chunk_type_e'(header_byte_i[7:6]);
        sid_d   = header_byte_i[SID_W-1:0];
        hp_d    = look.hit;
        acc_d   = '0;
        for (int i = 0; i < BODY_BYTES; i++) begin
          coll_d[i] = '0;
        end
        bidx_d  = '0;
        if ((ctype_d == CT_DELTA || ctype_d == CT_NONE) && !look.hit) begin
          // no previous header to fill from
          emit     = 1'b1;
          emit_err = 1'b1;
        end else if (ctype_d == CT_NONE) begin
          if (look.ext) begin
            bidx_d = 4'd1;
          end else begin
            emit = 1'b1;
          end
        end else begin
          bidx_d = 4'd1;
        end
      end else if (bidx_q <= n_len) begin
        // message header byte
        for (int i = 0; i < BODY_BYTES; i++) begin
          if (BIDX_W'(i + 1) == bidx_q) begin
            coll_d[i] = header_byte_i;
          end
        end
        if (bidx_q == n_len && {coll_d[0], coll_d[1], coll_d[2]} != ALL24) begin
          emit   = 1'b1;
          bidx_d = '0;
        end else begin
          bidx_d = bidx_q + 1'b1;
        end
      end else begin
        // extended timestamp byte, big-endian
        acc_d = {acc_q[23:0], header_byte_i};
        if (bidx_q >= n_len + EXT_BYTES) begin
          emit     = 1'b1;
          emit_ext = 1'b1;
          bidx_d   = '0;
        end else begin
          bidx_d = bidx_q + 1'b1;
        end
      end
    end
  end

  // Snapshot for the result stage
  always_comb begin
    s1_d.ctype = ctype_d;
    s1_d.sid   = sid_d;
    s1_d.hp    = hp_d;
    s1_d.ext   = emit_ext;
    s1_d.err   = emit_err;
    s1_d.f0    = {coll_d[0], coll_d[1], coll_d[2]};
    s1_d.len   = {coll_d[3], coll_d[4], coll_d[5]};
    s1_d.mtype = coll_d[6];
    s1_d.msid  = {coll_d[10], coll_d[9], coll_d[8], coll_d[7]};
    s1_d.acc   = acc_d;
  end

  // Result stage: fill absent fields and resolve the timestamp
  assign pm = s1_q.hp ? prev : '0;

  always_comb begin
    res = '0;
    case (s1_q.ctype)
      CT_FULL: begin
        res.delta = '0;
        res.len   = s1_q.len;
        res.mtype = s1_q.mtype;
        res.msid  = s1_q.msid;
      end
      CT_NO_MSID: begin
        res.delta = s1_q.f0;
        res.len   = s1_q.len;
        res.mtype = s1_q.mtype;
        res.msid  = pm.msid;
      end
      CT_DELTA: begin
        res.delta = s1_q.f0;
        res.len   = pm.len;
        res.mtype = pm.mtype;
        res.msid  = pm.msid;
      end
      default: begin
        // type 3 repeats the stored delta
        res.delta = s1_q.ext ? ALL24 : pm.delta;
        res.len   = pm.len;
        res.mtype = pm.mtype;
        res.msid  = pm.msid;
      end
    endcase
    ts_sum = pm.ts + {8'd0, res.delta};
    if (s1_q.ext) begin
      res.ts = s1_q.acc;
    end else if (s1_q.ctype == CT_FULL) begin
      res.ts = {8'd0, s1_q.f0};
    end else begin
      res.ts = ts_sum;
    end
    if (s1_q.err) begin
      res = '0;
    end
  end

  // Table write-back when a result without error moves on
  assign wr.en   = s1_adv && !s1_q.err;
  assign wr.sid  = s1_q.sid;
  assign wr.data = res;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bidx_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bidx_q <= bidx_d;
      if (in_acc) begin
        s1_valid_q <= emit;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ctype_q <= ctype_d;
    sid_q   <= sid_d;
    hp_q    <= hp_d;
    acc_q   <= acc_d;
    coll_q  <= coll_d;
    if (in_acc && emit) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_q.sid    <= s1_q.sid;
      out_q.ctype  <= s1_q.ctype;
      out_q.hdr    <= res;
      out_q.status <= s1_q.err;
    end
  end

  // Outputs
  assign out_valid_o          = out_valid_q;
  assign chunk_stream_id_o    = out_q.sid;
  assign chunk_type_o         = out_q.ctype;
  assign absolute_timestamp_o = out_q.hdr.ts;
  assign timestamp_delta_o    = out_q.hdr.delta;
  assign message_length_o     = out_q.hdr.len;
  assign message_type_o       = out_q.hdr.mtype;
  assign message_stream_id_o  = out_q.hdr.msid;
  assign status_o             = out_q.status;

endmodule

[verif/tb.sv]
// Testbench for rtmp_chunk_header_parser: byte-wise chunk header stimulus,
// a self-checking scoreboard that decodes headers on its own, random idling.
// Depends on rtmpch_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb;
  import rtmpch_pkg::*;

  localparam int NUM_STREAMS  = 64;
  localparam int RANDOM_BYTES = 400;
  localparam int HOLD_CYCLES  = 60;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  // One decoded header as seen on the output ports
  typedef struct packed {
    logic [5:0]  sid;
    logic [1:0]  ctype;
    logic [31:0] ts;
    logic [23:0] delta;
    logic [23:0] len;
    logic [7:0]  mtype;
    logic [31:0] msid;
    logic        status;
  } hdr_result_t;

  // Decodes the accepted byte stream and checks the headers that come out
  class chunk_header_scoreboard;
    bit [3:0]     byte_idx;
    chunk_type_e  cur_type;
    bit [5:0]     cur_sid;
    bit [31:0]    ext_ts;
    bit [7:0]     body [BODY_BYTES];
    bit           known [NUM_STREAMS];
    hdr_entry_t   hist [NUM_STREAMS];
    hdr_result_t  pending_headers [$];
    int           errors;
    int           headers_seen;
    int           no_history_seen;

    function bit has_prev(bit [5:0] sid);
      return (sid < NUM_STREAMS) && known[sid];
    endfunction

    function bit [23:0] be24(int at);
      return {body[at], body[at+1], body[at+2]};
    endfunction

    function bit ext_needed();
      if (cur_type == CT_NONE) return hist[cur_sid].delta == ALL24;
      return be24(0) == ALL24;
    endfunction

    // Fill absent fields from the stream history and queue the header
    function void decode_header(bit ext);
      hdr_entry_t  prev;
      hdr_entry_t  h;
      hdr_result_t r;
      prev = '0;
      if (has_prev(cur_sid)) prev = hist[cur_sid];
      h = prev;
      case (cur_type)
        CT_FULL: begin
          h.ts    = ext ? ext_ts : {8'h00, be24(0)};
          h.delta = '0;
          h.len   = be24(3);
          h.mtype = body[6];
          h.msid  = {body[10], body[9], body[8], body[7]};
        end
        CT_NO_MSID: begin
          h.delta = be24(0);
          h.len   = be24(3);
          h.mtype = body[6];
          h.ts    = ext ? ext_ts : prev.ts + h.delta;
        end
        CT_DELTA: begin
          h.delta = be24(0);
          h.ts    = ext ? ext_ts : prev.ts + h.delta;
        end
        default: begin
          h.delta = ext ? ALL24 : prev.delta;
          h.ts    = ext ? ext_ts : prev.ts + h.delta;
        end
      endcase
      if (cur_sid < NUM_STREAMS) begin
        known[cur_sid] = 1'b1;
        hist[cur_sid]  = h;
      end
      r = '{sid: cur_sid, ctype: cur_type, ts: h.ts, delta: h.delta, len: h.len,
            mtype: h.mtype, msid: h.msid, status: 1'b0};
      pending_headers.push_back(r);
      byte_idx = '0;
    endfunction

    // Advance the parse by one accepted byte
    function void note_byte(bit [7:0] b, bit start);
      bit [3:0]    n;
      hdr_result_t r;
      if (byte_idx == 0 || start) begin
        cur_type = chunk_type_e'(b[7:6]);
        cur_sid  = b[5:0];
        ext_ts   = '0;
        body     = '{default: 8'h00};
        byte_idx = '0;
        if ((cur_type == CT_DELTA || cur_type == CT_NONE) && !has_prev(cur_sid)) begin
          r = '0;
          r.sid    = cur_sid;
          r.ctype  = cur_type;
          r.status = 1'b1;
          pending_headers.push_back(r);
          return;
        end
        if (cur_type == CT_NONE && !ext_needed()) decode_header(1'b0);
        else byte_idx = 4'd1;
        return;
      end
      case (cur_type)
        CT_FULL:    n = BODY_LEN_FULL;
        CT_NO_MSID: n = BODY_LEN_NO_MSID;
        CT_DELTA:   n = BODY_LEN_DELTA;
        default:    n = BODY_LEN_NONE;
      endcase
      if (byte_idx <= n) begin
        body[byte_idx-1] = b;
        if (byte_idx == n && !ext_needed()) begin
          decode_header(1'b0);
          return;
        end
        byte_idx++;
        return;
      end
      // extended timestamp bytes, big-endian
      ext_ts = {ext_ts[23:0], b};
      if (byte_idx >= n + EXT_BYTES) decode_header(1'b1);
      else byte_idx++;
    endfunction

    function void compare_field(string name, bit [31:0] want, bit [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_header(hdr_result_t got);
      hdr_result_t want;
      if (pending_headers.size() == 0) begin
        $error("header item with none expected: sid %0d type %0d", got.sid, got.ctype);
        errors++;
        return;
      end
      want = pending_headers.pop_front();
      headers_seen++;
      if (want.status) no_history_seen++;
      compare_field("chunk_stream_id", want.sid, got.sid);
      compare_field("chunk_type", want.ctype, got.ctype);
      compare_field("absolute_timestamp", want.ts, got.ts);
      compare_field("timestamp_delta", want.delta, got.delta);
      compare_field("message_length", want.len, got.len);
      compare_field("message_type", want.mtype, got.mtype);
      compare_field("message_stream_id", want.msid, got.msid);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  hdr_byte = 8'h00;
  logic        sof = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  hdr_result_t out_hdr;

  chunk_header_scoreboard sb;
  int idle_phase = 0;
  int bytes_sent = 0;
  int quiet = 0;
  bit hold_done = 1'b0;
  int tx_idle_pct [3] = '{23, 64, 0};
  int rx_idle_pct [3] = '{64, 23, 0};

  rtmp_chunk_header_parser #(.STREAM_IDS(NUM_STREAMS)) uut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .header_byte_i       (hdr_byte),
    .start_of_header_i   (sof),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .chunk_stream_id_o   (out_hdr.sid),
    .chunk_type_o        (out_hdr.ctype),
    .absolute_timestamp_o(out_hdr.ts),
    .timestamp_delta_o   (out_hdr.delta),
    .message_length_o    (out_hdr.len),
    .message_type_o      (out_hdr.mtype),
    .message_stream_id_o (out_hdr.msid),
    .status_o            (out_hdr.status)
  );

  always #6 clk = ~clk;

  // Offer one byte after random idling, and wait until it is taken
  task automatic send_byte(input bit [7:0] b, input bit s);
    while ($urandom_range(0, 99) < tx_idle_pct[idle_phase]) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    hdr_byte <= b;
    sof      <= s;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, s);
    bytes_sent++;
  endtask

  // Build one chunk header; cut > 0 truncates it to at most that many bytes
  task automatic send_header(input bit [5:0] sid, input chunk_type_e ct, input bit s,
                             input int cut, input bit [23:0] f24, input bit [23:0] len,
                             input bit [7:0] mtype, input bit [31:0] msid,
                             input bit [31:0] xts);
    bit [7:0] bytes [$];
    bit       ext;
    bytes.push_back({ct, sid});
    // no-history type 2/3 ends at the basic header
    if (!((ct == CT_DELTA || ct == CT_NONE) && !sb.has_prev(sid))) begin
      if (ct != CT_NONE) bytes = {bytes, f24[23:16], f24[15:8], f24[7:0]};
      if (ct == CT_FULL || ct == CT_NO_MSID)
        bytes = {bytes, len[23:16], len[15:8], len[7:0], mtype};
      if (ct == CT_FULL) bytes = {bytes, msid[7:0], msid[15:8], msid[23:16], msid[31:24]};
      ext = (ct == CT_NONE) ? (sb.hist[sid].delta == ALL24) : (f24 == ALL24);
      if (ext) bytes = {bytes, xts[31:24], xts[23:16], xts[15:8], xts[7:0]};
    end
    if (cut > 0 && cut < bytes.size()) bytes = bytes[0:cut-1];
    foreach (bytes[i]) send_byte(bytes[i], (i == 0) ? s : 1'b0);
  endtask

  function automatic bit [23:0] rand24();
    case ($urandom_range(0, 5))
      0:       return ALL24;
      1:       return '0;
      2:       return 24'($urandom_range(0, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic bit [31:0] rand32();
    case ($urandom_range(0, 4))
      0:       return '1;
      1:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus
  initial begin
    int          rand_start;
    int          r;
    int          cut;
    bit          broken;
    bit [5:0]    sid;
    chunk_type_e ct;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no history yet: type 3 and type 2 report errors
    send_header(6'd5, CT_NONE, 1'b1, 0, '0, '0, '0, '0, '0);
    send_header(6'd63, CT_DELTA, 1'b0, 0, '0, '0, '0, '0, '0);
    // type 1 without history, then type 3 repeating its delta
    send_header(6'd7, CT_NO_MSID, 1'b0, 0, 24'h10, ALL24, 8'hFF, '0, '0);
    send_header(6'd7, CT_NONE, 1'b0, 0, '0, '0, '0, '0, '0);
    // type 0 with extended timestamp, then a delta that wraps past 2^32
    send_header(6'd0, CT_FULL, 1'b1, 0, ALL24, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_header(6'd0, CT_DELTA, 1'b0, 0, 24'h20, '0, '0, '0, '0);
    // partial header dropped by the start flag
    send_header(6'd1, CT_FULL, 1'b0, 3, 24'h123456, '0, '0, '0, '0);
    // type 1 extended, then type 3 that inherits the extended delta
    send_header(6'd0, CT_NO_MSID, 1'b1, 0, ALL24, 24'h40, 8'h14, '0, 32'h0);
    send_header(6'd0, CT_NONE, 1'b0, 0, '0, '0, '0, '0, 32'h1234_5678);

    // random headers, with some truncated ones and some noise bytes
    rand_start = bytes_sent;
    broken = 1'b0;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      idle_phase = (bytes_sent - rand_start) * 3 / RANDOM_BYTES;
      if (idle_phase > 2) idle_phase = 2;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_byte(8'($urandom), 1'($urandom_range(0, 1)));
        broken = 1'b1;
      end else begin
        sid = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, 5));
        ct  = chunk_type_e'($urandom_range(0, 3));
        cut = (r < 15) ? $urandom_range(1, 6) : 0;
        send_header(sid, ct, broken ? 1'b1 : 1'(($urandom_range(0, 1))), cut,
                    rand24(), rand24(), 8'($urandom), rand32(), rand32());
        broken = (cut != 0);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run: %0d header bytes in, %0d headers checked, %0d of them no-history errors",
             bytes_sent, sb.headers_seen, sb.no_history_seen);
    $display("run: three idling mixes and one long output hold with input backpressure");
    if (sb.errors == 0) $display("[rtmp_chunk_header_parser] OK");
    else $display("[rtmp_chunk_header_parser] ERROR");
    $finish;
  end

  // Output side stall, with one long hold once idling stops
  initial begin
    forever begin
      @(posedge clk);
      if (idle_phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct[idle_phase]);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_header(out_hdr);
  end

  // Watchdog: too long without any item moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("[rtmp_chunk_header_parser] ERROR");
        $finish;
      end
    end
  end

endmodule
